// File: rtl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder package
// Shared types, character constants and hex helpers for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Character constants.
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [3:0] DEC_LIMIT  = 4'd10;

    // Most result beats one input beat can cause.
    localparam int unsigned RUN_DEPTH = 3;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_DEPTH + 1);

    // Escape phase, one-hot.
    typedef enum logic [2:0] {
        PH_TEXT  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    // One pending result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } slot_t;

    // True if the byte is a hex digit in either case.
    function automatic logic is_hex(input logic [7:0] ch);
        logic [7:0] lc;
        lc = ch | CASE_BIT;
        return ((ch >= CHAR_0) && (ch <= CHAR_9)) ||
               ((lc >= CHAR_LC_A) && (lc <= CHAR_LC_F));
    endfunction

    // Value of a hex digit; only meaningful when is_hex() holds.
    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] lc;
        lc = ch | CASE_BIT;
        if ((ch >= CHAR_0) && (ch <= CHAR_9))
        begin
            return ch[3:0];
        end
        // 'a' is 0x61, so the low nibble plus nine gives ten.
        return lc[3:0] + 4'd9;
    endfunction

    // Lower-case hex character for a nibble.
    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n < DEC_LIMIT)
        begin
            return CHAR_0 | {4'h0, n};
        end
        return (CHAR_LC_A - {4'h0, DEC_LIMIT}) + {4'h0, n};
    endfunction

endpackage

// File: rtl/uri_percent_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder
// Streaming decoder of %XX escapes with literal pass-through of bad escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one URI byte (req_type 0) or an end-of-string marker
//   (req_type 1). Each input beat causes zero to three result beats; the last
//   beat of that group has run_last set, and the final beat of an end marker
//   has string_end set. A bare end marker yields one beat with byte_valid 0.
//   Results of a beat appear on the output in the cycle after it is
//   accepted. One input beat is taken per cycle while each beat causes at
//   most one result and out_ready stays high; a beat that causes more
//   results holds the input off while the output run register drains one
//   result per cycle on out_ready. The input is ready when the run register
//   is empty, or when its last result is taken in the same cycle.
//   If the receiver stalls, the run register holds. Beats that cause no
//   result are still taken, and the input stops once the run register holds
//   results.
//   Reset clears the escape state to plain text and empties the run register.
// ----------------------------------------------------------------------------
module uri_percent_decoder_top
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       string_end
);

    phase_t                 phase_reg, phase_next;
    logic [3:0]             nibble_reg, nibble_next;
    logic [RUN_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   end_reg, end_next;
    slot_t                  slot_reg  [RUN_DEPTH];
    slot_t                  slot_next [RUN_DEPTH];

    logic                   in_fire;
    logic                   out_fire;
    logic                   hex_ok;
    logic [3:0]             hex_val;
    logic [RUN_CNT_W-1:0]   load_cnt;
    slot_t                  load_slot [RUN_DEPTH];

    // Handshake.
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == '0) ||
                       ((cnt_reg == RUN_CNT_W'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;

    // Output beat comes from the head of the run register.
    assign out_byte   = slot_reg[0].data;
    assign byte_valid = slot_reg[0].valid;
    assign run_last   = (cnt_reg == RUN_CNT_W'(1));
    assign string_end = run_last && end_reg;

    assign hex_ok  = is_hex(in_byte);
    assign hex_val = hex_value(in_byte);

    // Decode one input beat into its run of results and the next escape state.
    always_comb
    begin
        load_cnt    = '0;
        end_next    = 1'b0;
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            load_slot[i] = '{data: 8'h00, valid: 1'b1};
        end

        if (req_type)
        begin
            // End of string: flush any pending escape and return the escape state to plain text.
            end_next    = 1'b1;
            phase_next  = PH_TEXT;
            nibble_next = 4'h0;
            unique case (phase_reg)
                PH_PCT:
                begin
                    load_slot[0] = '{data: PCT_CHAR, valid: 1'b1};
                    load_cnt     = RUN_CNT_W'(1);
                end
                PH_DIGIT:
                begin
                    load_slot[0] = '{data: PCT_CHAR, valid: 1'b1};
                    load_slot[1] = '{data: nibble_char(nibble_reg), valid: 1'b1};
                    load_cnt     = RUN_CNT_W'(2);
                end
                default:
                begin
                    load_slot[0] = '{data: 8'h00, valid: 1'b0};
                    load_cnt     = RUN_CNT_W'(1);
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    if (hex_ok)
                    begin
                        nibble_next = hex_val;
                        phase_next  = PH_DIGIT;
                    end
                    else
                    begin
                        // Bad first digit: pass '%' and the byte through.
                        load_slot[0] = '{data: PCT_CHAR, valid: 1'b1};
                        load_slot[1] = '{data: in_byte, valid: 1'b1};
                        load_cnt     = RUN_CNT_W'(2);
                        phase_next   = PH_TEXT;
                    end
                end
                PH_DIGIT:
                begin
                    phase_next = PH_TEXT;
                    if (hex_ok)
                    begin
                        load_slot[0] = '{data: {nibble_reg, hex_val}, valid: 1'b1};
                        load_cnt     = RUN_CNT_W'(1);
                    end
                    else
                    begin
                        // Bad second digit: '%', the first digit, then the byte.
                        load_slot[0] = '{data: PCT_CHAR, valid: 1'b1};
                        load_slot[1] = '{data: nibble_char(nibble_reg), valid: 1'b1};
                        load_slot[2] = '{data: in_byte, valid: 1'b1};
                        load_cnt     = RUN_CNT_W'(3);
                    end
                end
                default:
                begin
                    // Plain text.
                    phase_next = PH_TEXT;
                    if (in_byte == PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        load_slot[0] = '{data: in_byte, valid: 1'b1};
                        load_cnt     = RUN_CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // Run register: load on input beat, otherwise shift on output beat.
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (in_fire)
        begin
            cnt_next = load_cnt;
            for (int i = 0; i < RUN_DEPTH; i++)
            begin
                slot_next[i] = load_slot[i];
            end
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - RUN_CNT_W'(1);
            for (int i = 0; i < RUN_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TEXT;
            nibble_reg <= 4'h0;
            cnt_reg    <= '0;
            end_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                nibble_reg <= nibble_next;
                end_reg    <= end_next;
            end
        end
    end

    // Payload slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RUN_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

// File: rtl/upd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker
    import upd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       string_end
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(byte_valid) && $stable(run_last) && $stable(string_end))
        else $error("output beat changed while stalled");

    // A beat with no byte is only the bare end marker.
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> string_end && run_last)
        else $error("empty beat is not a closing end marker");

    // The end of a string always closes its run.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end without run end");

    // A run that is not finished continues in the next cycle.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("run broken before its last beat");

    // The input only stalls while results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

endmodule

bind uri_percent_decoder_top upd_checker u_upd_checker (.*);

// File: tb/sv/uri_percent_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder testbench
// Drives URI bytes and end-of-string markers through the decoder with bursty
// input and a stalling receiver. A scoreboard tracks the escape state, works
// out the beats each input should cause, and compares every output beat in
// order, field by field.
// ----------------------------------------------------------------------------
module uri_percent_decoder_top_test;

    import upd_pkg::*;

    // Input beat kinds.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam int RANDOM_BEATS   = 350;
    localparam int HOLD_CYCLES    = 60;
    localparam int unsigned LIMIT = 400000;

    // Hand-picked opening beats: byte extremes, good and bad escapes, and
    // every way a string can end.
    localparam int DIRECTED_COUNT = 25;
    localparam logic [8:0] DIRECTED_BEATS [DIRECTED_COUNT] = '{
        {REQ_DATA, 8'h41}, {REQ_DATA, 8'hFF},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h46}, {REQ_DATA, 8'h66},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h30}, {REQ_DATA, 8'h39},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h67},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h41}, {REQ_DATA, 8'h7A},
        {REQ_END, 8'hFF},
        {REQ_DATA, PCT_CHAR}, {REQ_END, 8'h00},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h42}, {REQ_END, 8'h25},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, PCT_CHAR},
        {REQ_DATA, PCT_CHAR}, {REQ_DATA, 8'h39}, {REQ_DATA, 8'h40},
        {REQ_DATA, 8'h00}
    };

    // One output beat as the decoder should present it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } dec_beat_t;

    // Tracks the escape state and holds the decoded beats still to come.
    class decode_scoreboard;
        phase_t     phase;
        logic [3:0] held_nibble;
        dec_beat_t  pending[$];
        int         errors;

        function new();
            phase       = PH_TEXT;
            held_nibble = 4'h0;
            errors      = 0;
        endfunction

        // Returns 1 and the digit value when the byte is a hex digit.
        static function logic hex_digit(input logic [7:0] ch, output logic [3:0] val);
            logic [7:0] lc;
            logic [7:0] diff;
            lc  = ch | CASE_BIT;
            val = 4'h0;
            if ((ch >= CHAR_0) && (ch <= CHAR_9))
            begin
                diff = ch - CHAR_0;
                val  = diff[3:0];
                return 1'b1;
            end
            if ((lc >= CHAR_LC_A) && (lc <= CHAR_LC_F))
            begin
                diff = lc - CHAR_LC_A + {4'h0, DEC_LIMIT};
                val  = diff[3:0];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Lower-case character that spells a nibble.
        static function logic [7:0] lower_digit(input logic [3:0] n);
            if (n < DEC_LIMIT)
            begin
                return CHAR_0 + {4'h0, n};
            end
            return CHAR_LC_A + {4'h0, n} - {4'h0, DEC_LIMIT};
        endfunction

        static function dec_beat_t byte_beat(input logic [7:0] b, input logic v);
            dec_beat_t r;
            r.out_byte   = b;
            r.byte_valid = v;
            r.run_last   = 1'b0;
            r.string_end = 1'b0;
            return r;
        endfunction

        // Advances the escape state for an accepted input beat and queues its results.
        function void note_beat(input logic req, input logic [7:0] ch);
            dec_beat_t  run [3];
            int         n;
            logic       is_hex;
            logic [3:0] val;
            n      = 0;
            is_hex = hex_digit(ch, val);
            if (req == REQ_END)
            begin
                if (phase == PH_TEXT)
                begin
                    run[n] = byte_beat(8'h00, 1'b0);
                    n++;
                end
                else
                begin
                    run[n] = byte_beat(PCT_CHAR, 1'b1);
                    n++;
                    if (phase == PH_DIGIT)
                    begin
                        run[n] = byte_beat(lower_digit(held_nibble), 1'b1);
                        n++;
                    end
                end
                run[n - 1].string_end = 1'b1;
                phase       = PH_TEXT;
                held_nibble = 4'h0;
            end
            else
            begin
                case (phase)
                    PH_PCT:
                    begin
                        if (is_hex)
                        begin
                            held_nibble = val;
                            phase       = PH_DIGIT;
                        end
                        else
                        begin
                            run[n] = byte_beat(PCT_CHAR, 1'b1);
                            n++;
                            run[n] = byte_beat(ch, 1'b1);
                            n++;
                            phase = PH_TEXT;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (is_hex)
                        begin
                            run[n] = byte_beat({held_nibble, val}, 1'b1);
                            n++;
                        end
                        else
                        begin
                            run[n] = byte_beat(PCT_CHAR, 1'b1);
                            n++;
                            run[n] = byte_beat(lower_digit(held_nibble), 1'b1);
                            n++;
                            run[n] = byte_beat(ch, 1'b1);
                            n++;
                        end
                        phase = PH_TEXT;
                    end
                    default:
                    begin
                        if (ch == PCT_CHAR)
                        begin
                            phase = PH_PCT;
                        end
                        else
                        begin
                            run[n] = byte_beat(ch, 1'b1);
                            n++;
                        end
                    end
                endcase
            end
            if (n > 0)
            begin
                run[n - 1].run_last = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                pending.push_back(run[i]);
            end
        endfunction

        // Compares one accepted output beat with the oldest queued result.
        function void check_beat(input logic [7:0] ob, input logic bv,
                                 input logic rl, input logic se);
            dec_beat_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected output beat: out_byte=%02h byte_valid=%0b", ob, bv);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (ob !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, ob);
                errors++;
            end
            if (bv !== want.byte_valid)
            begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, bv);
                errors++;
            end
            if (rl !== want.run_last)
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, rl);
                errors++;
            end
            if (se !== want.string_end)
            begin
                $error("string_end: expected %0b, got %0b", want.string_end, se);
                errors++;
            end
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       req_type   = 1'b0;
    logic [7:0] in_byte    = 8'h00;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    decode_scoreboard sb = new();

    int unsigned cycle_count  = 0;
    logic        hold_request = 1'b0;
    int          hold_left    = 0;
    int          ready_mode   = 0;
    int          mode_cycles  = 0;
    int          burst_left   = 0;
    int          beats_sent   = 0;

    uri_percent_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    // Clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Cycle count and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: checks each taken beat, then picks the next ready value.
    // Ready follows a rotating pattern, with long hold-offs on request.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_beat(out_byte, byte_valid, run_last, string_end);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            mode_cycles++;
            if (mode_cycles == 40)
            begin
                mode_cycles = 0;
                ready_mode  = (ready_mode + 1) % 4;
            end
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ((mode_cycles % 4) != 3);
                2:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offers one beat and waits until the decoder takes it.
    task automatic send_beat(input logic req, input logic [7:0] b);
        in_valid <= 1'b1;
        req_type <= req;
        in_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_beat(req, b);
        beats_sent++;
    endtask

    // Sends a beat, then idles for a random gap when the current burst runs out.
    task automatic send_paced(input logic req, input logic [7:0] b);
        send_beat(req, b);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 20);
        end
    endtask

    // Idles the input until every queued result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        logic [3:0] v;
        logic [7:0] c;
        v = 4'($urandom_range(0, 15));
        c = decode_scoreboard::lower_digit(v);
        // Letters come in either case.
        if ((v >= DEC_LIMIT) && ($urandom_range(0, 1) == 1))
        begin
            c = c & ~CASE_BIT;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        c = 8'($urandom_range(0, 255));
        while (decode_scoreboard::hex_digit(c, v))
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Well-formed escapes with random digits as the most common kind, plus plain
    // bytes, broken escapes and string ends.
    task automatic send_random_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            send_paced(REQ_DATA, PCT_CHAR);
            send_paced(REQ_DATA, rand_hex());
            send_paced(REQ_DATA, rand_hex());
        end
        else if (kind < 60)
        begin
            send_paced(REQ_DATA, 8'($urandom_range(0, 255)));
        end
        else if (kind < 70)
        begin
            send_paced(REQ_DATA, PCT_CHAR);
            send_paced(REQ_DATA, rand_non_hex());
        end
        else if (kind < 80)
        begin
            send_paced(REQ_DATA, PCT_CHAR);
            send_paced(REQ_DATA, rand_hex());
            send_paced(REQ_DATA, rand_non_hex());
        end
        else if (kind < 90)
        begin
            send_paced(REQ_END, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_paced(REQ_DATA, PCT_CHAR);
            if ($urandom_range(0, 1) == 1)
            begin
                send_paced(REQ_DATA, rand_hex());
            end
            send_paced(REQ_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // Main sequence.
    initial
    begin
        logic hold_done;
        logic pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, back to back.
        burst_left = DIRECTED_COUNT;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_paced(DIRECTED_BEATS[i][8], DIRECTED_BEATS[i][7:0]);
        end
        drain_results();

        // Random sequences, with one long receiver hold-off and one full pause.
        while (beats_sent < DIRECTED_COUNT + RANDOM_BEATS)
        begin
            if (!hold_done && (beats_sent >= DIRECTED_COUNT + 100))
            begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                burst_left   = 50;
            end
            if (!pause_done && (beats_sent >= DIRECTED_COUNT + 220))
            begin
                pause_done = 1'b1;
                drain_results();
            end
            send_random_sequence();
        end

        drain_results();
        repeat (8) @(posedge clk);

        if (sb.pending.size() != 0)
        begin
            $error("%0d expected output beats never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
